// ===== rtl/cordic_pkg.sv =====
// Constants, types and lookup functions for the CORDIC sine/cosine pipeline.
package cordic_pkg;

    localparam int ANGLE_W = 14;
    localparam int OUT_W   = 14;
    localparam int VEC_W   = 15;
    localparam int STEP_W  = 4;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic [ANGLE_W-1:0]      angle_t;
    typedef logic signed [OUT_W-1:0] result_t;

    // arctan(2^-i), 4096 units per quarter turn
    function automatic vec_t atan_units(input logic [STEP_W-1:0] i);
        vec_t r;
        unique case (i)
            4'd0:    r = 15'sd2048;
            4'd1:    r = 15'sd1209;
            4'd2:    r = 15'sd639;
            4'd3:    r = 15'sd324;
            4'd4:    r = 15'sd163;
            4'd5:    r = 15'sd81;
            4'd6:    r = 15'sd41;
            4'd7:    r = 15'sd20;
            4'd8:    r = 15'sd10;
            4'd9:    r = 15'sd5;
            4'd10:   r = 15'sd3;
            4'd11:   r = 15'sd1;
            4'd12:   r = 15'sd1;
            default: r = 15'sd0;
        endcase
        return r;
    endfunction

    // gain-corrected start value for n rotation steps
    function automatic vec_t start_x(input logic [STEP_W-1:0] n);
        vec_t r;
        unique case (n)
            4'd0:    r = 15'sd4096;
            4'd1:    r = 15'sd2896;
            4'd2:    r = 15'sd2591;
            4'd3:    r = 15'sd2513;
            4'd4:    r = 15'sd2494;
            4'd5:    r = 15'sd2489;
            4'd6:    r = 15'sd2488;
            default: r = 15'sd2487;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cordic_sin_cos_top.sv =====
// Pipelined CORDIC sine/cosine: quadrant fold, one rotation stage per step, sign stage.
//
// Usage:
//   Input channel s_*: one angle per beat in s_tdata[13:0], 16384 units per turn.
//   Result channel m_*: sine in m_tdata[13:0], cosine in m_tdata[27:14], both
//   two's complement and scaled by 4096. Every input beat gives one result beat.
//   Path from input beat to m_tvalid: fold register, ITERATIONS rotation registers,
//   output register.
//   Throughput: one angle per clock unless m_tready stalls; each rotation step
//   owns its own shift-add register stage, so nothing is shared between items.
//   Stall: every stage has its own valid bit and loads when empty or when the
//   stage after it moves, so bubbles collapse. While m_tready is low the results
//   hold and s_tready drops only once every stage holds a beat.
//   Reset: aresetn low (synchronous) clears all valid bits; in-flight beats are
//   dropped and s_tready is high in the first cycle after reset.
module cordic_sin_cos_top #(
    parameter int ITERATIONS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] angle, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [13:0] sine_value, [27:14] cosine_value, [31:28] zero
);

    localparam cordic_pkg::vec_t XSTART =
        cordic_pkg::start_x(cordic_pkg::STEP_W'(ITERATIONS));

    // stage 0 holds the folded angle, stage k the vector after k rotations
    logic [ITERATIONS:0]  valid_reg;
    logic [ITERATIONS+1:0] rdy;
    cordic_pkg::vec_t     x_reg [0:ITERATIONS];
    cordic_pkg::vec_t     y_reg [0:ITERATIONS];
    cordic_pkg::vec_t     z_reg [0:ITERATIONS];
    logic [ITERATIONS:0]  negc_reg;
    logic [ITERATIONS:0]  negs_reg;

    logic                 m_valid_reg;
    cordic_pkg::result_t  sin_reg;
    cordic_pkg::result_t  cos_reg;

    cordic_pkg::angle_t   angle;
    logic [1:0]           quad;
    logic [11:0]          low;
    logic [12:0]          z_fold;

    assign rdy[ITERATIONS+1] = !m_valid_reg || m_tready;

    genvar k;
    generate
        for (k = 0; k <= ITERATIONS; k++) begin : g_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    endgenerate

    assign s_tready = rdy[0];

    // fold into the first quadrant
    assign angle  = s_tdata[cordic_pkg::ANGLE_W-1:0];
    assign quad   = angle[13:12];
    assign low    = angle[11:0];
    assign z_fold = quad[0] ? (13'd4096 - {1'b0, low}) : {1'b0, low};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            valid_reg[0] <= s_tvalid;
        end
        if (rdy[0] && s_tvalid) begin
            x_reg[0]    <= XSTART;
            y_reg[0]    <= '0;
            z_reg[0]    <= cordic_pkg::vec_t'({2'b00, z_fold});
            negc_reg[0] <= quad[1] ^ quad[0];
            negs_reg[0] <= quad[1];
        end
    end

    generate
        for (k = 1; k <= ITERATIONS; k++) begin : g_step
            cordic_pkg::vec_t atan_k;
            cordic_pkg::vec_t xs;
            cordic_pkg::vec_t ys;
            logic             pos;

            assign atan_k = cordic_pkg::atan_units(cordic_pkg::STEP_W'(k - 1));
            assign xs     = x_reg[k-1] >>> (k - 1);
            assign ys     = y_reg[k-1] >>> (k - 1);
            assign pos    = (z_reg[k-1] > 0);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
                if (rdy[k] && valid_reg[k-1]) begin
                    if (pos) begin
                        z_reg[k] <= z_reg[k-1] - atan_k;
                        y_reg[k] <= y_reg[k-1] + xs;
                        x_reg[k] <= x_reg[k-1] - ys;
                    end else begin
                        z_reg[k] <= z_reg[k-1] + atan_k;
                        y_reg[k] <= y_reg[k-1] - xs;
                        x_reg[k] <= x_reg[k-1] + ys;
                    end
                    negc_reg[k] <= negc_reg[k-1];
                    negs_reg[k] <= negs_reg[k-1];
                end
            end
        end
    endgenerate

    cordic_pkg::vec_t cos_next;
    cordic_pkg::vec_t sin_next;

    assign cos_next = negc_reg[ITERATIONS] ? -x_reg[ITERATIONS] : x_reg[ITERATIONS];
    assign sin_next = negs_reg[ITERATIONS] ? -y_reg[ITERATIONS] : y_reg[ITERATIONS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[ITERATIONS+1]) begin
            m_valid_reg <= valid_reg[ITERATIONS];
        end
        if (rdy[ITERATIONS+1] && valid_reg[ITERATIONS]) begin
            sin_reg <= sin_next[cordic_pkg::OUT_W-1:0];
            cos_reg <= cos_next[cordic_pkg::OUT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, cos_reg, sin_reg};

    // accepted beat lands in the fold stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat not captured by fold stage");

    // input backpressure only when the whole pipe is full and stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg && m_valid_reg && !m_tready))
        else $error("s_tready low with room in the pipeline");

    // a stalled result holds its value
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // last rotation stage hands off to the output register when it moves
    a_last_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ITERATIONS] && rdy[ITERATIONS+1]) |=> m_valid_reg)
        else $error("last stage beat lost on handoff");

endmodule

// ===== tb/sv/cordic_sin_cos_top_tb.sv =====
// Self-checking stream testbench for the pipelined CORDIC sine/cosine block.
module cordic_sin_cos_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS       = 12;
    localparam int LATENCY     = STEPS + 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUARTER     = 4096;
    localparam int HALF        = 8192;
    localparam int FULL        = 16384;

    typedef struct {
        cordic_pkg::angle_t  angle;
        cordic_pkg::result_t sine;
        cordic_pkg::result_t cosine;
    } trig_t;

    // arctan(2^-i) in 1/4096 of a quarter turn, and the gain-corrected start vector
    localparam int ARCTAN[14] = '{2048, 1209, 639, 324, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    localparam int X_INIT[15] = '{4096, 2896, 2591, 2513, 2494, 2489, 2488, 2487,
                                  2487, 2487, 2487, 2487, 2487, 2487, 2487};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [13:0] angle, [15:14] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [13:0] sine_value, [27:14] cosine_value, [31:28] zero

    cordic_pkg::angle_t angles_pending[$];
    trig_t  trig_expected[$];
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     fail_count     = 0;
    int     checked_count  = 0;
    int     cycle_count    = 0;

    cordic_sin_cos_top #(
        .ITERATIONS(STEPS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic trig_t predict_sin_cos(input cordic_pkg::angle_t a);
        int    theta;
        int    z;
        int    x;
        int    y;
        int    nx;
        int    ny;
        bit    neg_cos;
        bit    neg_sin;
        trig_t r;
        theta = int'(a);
        neg_cos = 1'b0;
        neg_sin = 1'b0;
        // fold into the first quadrant, remember which signs to flip
        if (theta < QUARTER) begin
            z = theta;
        end else if (theta < HALF) begin
            z = HALF - theta;
            neg_cos = 1'b1;
        end else if (theta < HALF + QUARTER) begin
            z = theta - HALF;
            neg_cos = 1'b1;
            neg_sin = 1'b1;
        end else begin
            z = FULL - theta;
            neg_sin = 1'b1;
        end
        x = X_INIT[STEPS];
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (z > 0) begin
                z  = z - ARCTAN[i];
                ny = y + (x >>> i);
                nx = x - (y >>> i);
            end else begin
                z  = z + ARCTAN[i];
                ny = y - (x >>> i);
                nx = x + (y >>> i);
            end
            x = nx;
            y = ny;
        end
        if (neg_cos) x = -x;
        if (neg_sin) y = -y;
        r.angle  = a;
        r.sine   = y[cordic_pkg::OUT_W-1:0];
        r.cosine = x[cordic_pkg::OUT_W-1:0];
        return r;
    endfunction

    // angle driver: hold a beat until taken, then maybe idle, else advance
    always @(posedge aclk) begin
        bit slot_free;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            slot_free = !s_tvalid;
            if (s_tvalid && s_tready) begin
                trig_expected.push_back(predict_sin_cos(s_tdata[cordic_pkg::ANGLE_W-1:0]));
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (angles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, angles_pending.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        trig_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (trig_expected.size() == 0) begin
                    $error("unexpected result beat: m_tdata = 0x%08h", m_tdata);
                    fail_count++;
                end else begin
                    want = trig_expected.pop_front();
                    checked_count++;
                    if (m_tdata[13:0] !== want.sine) begin
                        $error("sine_value (angle %0d): expected %0d, actual %0d", want.angle,
                               want.sine, $signed(m_tdata[13:0]));
                        fail_count++;
                    end
                    if (m_tdata[27:14] !== want.cosine) begin
                        $error("cosine_value (angle %0d): expected %0d, actual %0d", want.angle,
                               want.cosine, $signed(m_tdata[27:14]));
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding", cycle_count,
                     trig_expected.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int pick;
        @(negedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(9);
            // mostly uniform angles, some hugging the quadrant boundaries
            if (pick < 8)
                angles_pending.push_back(cordic_pkg::angle_t'($urandom_range(FULL - 1)));
            else
                angles_pending.push_back(cordic_pkg::angle_t'($urandom_range(3) * QUARTER
                                                              + $urandom_range(4) - 2));
        end
        while (angles_pending.size() > 0)
            @(negedge aclk);
    endtask

    initial begin
        cordic_pkg::angle_t corners[$];
        corners = '{14'd0, 14'd1, 14'd2, 14'd2048, 14'd4095, 14'd4096, 14'd4097, 14'd6144,
                    14'd8191, 14'd8192, 14'd8193, 14'd10240, 14'd12287, 14'd12288,
                    14'd12289, 14'd14336, 14'd16382, 14'd16383, 14'd1365, 14'd2731,
                    14'h2AAA, 14'h1555};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        foreach (corners[k])
            angles_pending.push_back(corners[k]);
        while (angles_pending.size() > 0)
            @(negedge aclk);

        run_phase(0, 0, 350);
        run_phase(85, 0, 150);
        run_phase(0, 85, 150);
        run_phase(10, 10, 280);

        // drain: last beat taken, every result back, then watch for strays
        while (s_tvalid || trig_expected.size() > 0)
            @(negedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);

        $display("Checked %0d sine/cosine results: corner and quadrant-edge angles, then",
                 checked_count);
        $display("random angles under free-flowing, sender-idle, receiver-stall and mixed pacing.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cordic_pkg.sv
rtl/cordic_sin_cos_top.sv
tb/sv/cordic_sin_cos_top_tb.sv
